// ===== rtl/etcp_pkg.sv =====
// Shared constants and controller/datapath interface types for the EEPROM
// transfer chunk planner. No dependencies.
package etcp_pkg;

  localparam int unsigned PageBytes   = 128;
  localparam int unsigned PageAw      = $clog2(PageBytes);
  localparam int unsigned BlockAw     = 16;
  localparam int unsigned MaxTransfer = 4096;
  localparam int unsigned MaxResults  = 64;
  localparam int unsigned LenW        = 13;
  localparam int unsigned CbW         = 8;
  localparam int unsigned CntW        = $clog2(MaxResults);
  localparam int unsigned BlkW        = 3;
  localparam int unsigned LastBlock   = 3;
  localparam int unsigned LimitReset  = 256;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic calc;
    logic emit_chunk;
    logic emit_err;
  } etcp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic len_zero;
    logic start_err;
    logic block_over;
    logic cut_err;
    logic last_chunk;
    logic out_free;
  } etcp_status_t;

endpackage

// ===== rtl/etcp_ctrl.sv =====
// Sequencing state machine of the chunk planner.
// Depends on etcp_pkg for the command and status structs.
module etcp_ctrl import etcp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  etcp_status_t status_i,
  output etcp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_CALC,
    S_EMIT,
    S_ERR
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o            = '0;
    state_d          = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.len_zero) begin
          state_d = S_IDLE;
        end else if (status_i.start_err) begin
          state_d = S_ERR;
        end else begin
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        if (status_i.block_over) begin
          state_d = S_ERR;
        end else begin
          cmd_o.calc = 1'b1;
          state_d    = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold until the output word slot frees up
        if (status_i.out_free) begin
          if (status_i.cut_err) begin
            cmd_o.emit_err = 1'b1;
            state_d        = S_IDLE;
          end else begin
            cmd_o.emit_chunk = 1'b1;
            state_d          = status_i.last_chunk ? S_IDLE : S_CALC;
          end
        end
      end
      S_ERR: begin
        if (status_i.out_free) begin
          cmd_o.emit_err = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/etcp_datapath.sv =====
// Request registers, chunk sizing, address advance and output word register.
// Depends on etcp_pkg for constants and the command and status structs.
module etcp_datapath import etcp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [LenW-1:0]       cfg_wdata_i,
  input  logic                  in_cmd_i,
  input  logic [CbW-1:0]        in_control_i,
  input  logic [BlockAw-1:0]    in_address_i,
  input  logic [LenW-1:0]       in_length_i,
  input  etcp_cmd_t             cmd_i,
  output etcp_status_t          status_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CbW-1:0]        out_control_o,
  output logic [BlockAw-1:0]    out_address_o,
  output logic [LenW-1:0]       out_length_o,
  output logic                  out_error_o,
  output logic                  out_last_o
);

  localparam logic [BlockAw:0] BlockSize = (BlockAw + 1)'(1) << BlockAw;

  logic [LenW-1:0]    limit_q;
  logic               is_read_q;
  logic [CbW-1:0]     cb_q;
  logic [1:0]         dev_q;
  logic [BlkW-1:0]    block_q;
  logic [BlockAw-1:0] addr_q;
  logic [LenW-1:0]    rem_q;
  logic [LenW-1:0]    chunk_q;
  logic [CntW-1:0]    count_q;

  logic               out_valid_q;
  logic [CbW-1:0]     out_control_q;
  logic [BlockAw-1:0] out_address_q;
  logic [LenW-1:0]    out_length_q;
  logic               out_error_q;
  logic               out_last_q;

  logic [LenW-1:0]    lim;
  logic [BlockAw:0]   room_rd;
  logic [LenW-1:0]    rd_fit;
  logic [LenW-1:0]    rd_chunk;
  logic [PageAw:0]    room_wr;
  logic [LenW-1:0]    wr_chunk;
  logic [LenW-1:0]    chunk_d;
  logic [BlockAw:0]   addr_sum;
  logic [BlockAw:0]   end_sum;
  logic [BlkW-1:0]    block_d;
  logic [CbW-1:0]     cb_d;

  // chunk sizing: reads stop at the block end and the chunk limit, writes at the page end
  always_comb begin
    lim      = (limit_q == '0) ? LenW'(1) : limit_q;
    room_rd  = BlockSize - {1'b0, addr_q};
    rd_fit   = ((BlockAw + 1)'(rem_q) < room_rd) ? rem_q : room_rd[LenW-1:0];
    rd_chunk = (rd_fit > lim) ? lim : rd_fit;
    room_wr  = (PageAw + 1)'(PageBytes) - {1'b0, addr_q[PageAw-1:0]};
    wr_chunk = (rem_q < LenW'(room_wr)) ? rem_q : LenW'(room_wr);
    chunk_d  = is_read_q ? rd_chunk : wr_chunk;
  end

  // advance: a carry out of the address moves to the next block at address zero
  always_comb begin
    addr_sum = {1'b0, addr_q} + (BlockAw + 1)'(chunk_q);
    block_d  = block_q + BlkW'(addr_sum[BlockAw]);
    cb_d     = {cb_q[CbW-1:4], 4'b0000} | {2'b00, block_d, 3'b000} | {5'b00000, dev_q, 1'b0};
    end_sum  = {1'b0, addr_q} + (BlockAw + 1)'(rem_q);
  end

  always_comb begin
    status_o.len_zero   = (rem_q == '0);
    status_o.start_err  = (rem_q > LenW'(MaxTransfer)) || (block_q[0] && (end_sum > BlockSize));
    status_o.block_over = (block_q > BlkW'(LastBlock));
    status_o.cut_err    = (count_q == CntW'(MaxResults - 1)) && (chunk_q < rem_q);
    status_o.last_chunk = (chunk_q == rem_q);
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LenW'(LimitReset);
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.load) begin
      count_q <= '0;
    end else if (cmd_i.emit_chunk) begin
      count_q <= count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      is_read_q <= in_cmd_i;
      cb_q      <= in_control_i;
      dev_q     <= in_control_i[2:1];
      block_q   <= {{(BlkW - 1){1'b0}}, in_control_i[3]};
      addr_q    <= in_address_i;
      rem_q     <= in_length_i;
    end else if (cmd_i.emit_chunk) begin
      rem_q   <= rem_q - chunk_q;
      addr_q  <= addr_sum[BlockAw-1:0];
      block_q <= block_d;
      cb_q    <= cb_d;
    end
    if (cmd_i.calc) begin
      chunk_q <= chunk_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_chunk || cmd_i.emit_err) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_chunk || cmd_i.emit_err) begin
      out_control_q <= cb_q;
      out_address_q <= addr_q;
      out_length_q  <= cmd_i.emit_err ? '0 : chunk_q;
      out_error_q   <= cmd_i.emit_err;
      out_last_q    <= cmd_i.emit_err || status_o.last_chunk;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_control_o = out_control_q;
  assign out_address_o = out_address_q;
  assign out_length_o  = out_length_q;
  assign out_error_o   = out_error_q;
  assign out_last_o    = out_last_q;

endmodule

// ===== rtl/eeprom_transfer_chunk_planner_top.sv =====
// Top level of the EEPROM transfer chunk planner: stream ports, word packing,
// controller and datapath. Depends on etcp_pkg, etcp_ctrl and etcp_datapath.
//
// Usage:
//   The slave stream takes one transfer request per word: tuser carries the
//   direction (0 write, 1 read), tdata the control byte, start address and
//   length. The master stream returns one word per bus transaction: control
//   byte, address and byte count in tdata, the error flag in tuser, and tlast
//   on the final word of the request. An error word has a zero count.
//   The chunk limit register is written through cfg_we_i / cfg_wdata_i while
//   no request is in flight; zero acts as one.
// Timing:
//   A request is taken only while the sequencer is idle. After acceptance the
//   request is checked, then each chunk is sized, then emitted while the
//   address advances. A zero-length request returns to idle with no result; a
//   rejected request yields its error word. When the receiver stalls, the
//   output word holds and the sequencer waits in its emit step. Reset empties
//   the output register, returns the sequencer to idle and sets the chunk
//   limit to 256.
module eeprom_transfer_chunk_planner_top import etcp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [LenW-1:0]    cfg_wdata_i,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  logic [39:0]        s_tdata_i,  // control_byte[7:0], start_address[23:8],
                                         // transfer_length[36:24], zeros[39:37]
  input  logic [0:0]         s_tuser_i,  // cmd[0]
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  output logic [39:0]        m_tdata_o,  // chunk_control[7:0], chunk_address[23:8],
                                         // chunk_length[36:24], zeros[39:37]
  output logic [0:0]         m_tuser_o,  // error_flag[0]
  output logic               m_tlast_o
);

  etcp_cmd_t          cmd;
  etcp_status_t       status;
  logic [CbW-1:0]     out_control;
  logic [BlockAw-1:0] out_address;
  logic [LenW-1:0]    out_length;
  logic               out_error;

  etcp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid_i),
    .in_ready_o (s_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  etcp_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_cmd_i      (s_tuser_i[0]),
    .in_control_i  (s_tdata_i[7:0]),
    .in_address_i  (s_tdata_i[23:8]),
    .in_length_i   (s_tdata_i[36:24]),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (m_tvalid_o),
    .out_ready_i   (m_tready_i),
    .out_control_o (out_control),
    .out_address_o (out_address),
    .out_length_o  (out_length),
    .out_error_o   (out_error),
    .out_last_o    (m_tlast_o)
  );

  assign m_tdata_o = {3'b000, out_length, out_address, out_control};
  assign m_tuser_o = out_error;

  // an error word always ends the request and carries no bytes
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tuser_o[0]) |-> (m_tlast_o && (m_tdata_o[36:24] == '0)))
    else $error("error word without tlast or with nonzero count");

  // a regular chunk never has a zero count
  a_chunk_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tuser_o[0]) |-> (m_tdata_o[36:24] != '0))
    else $error("chunk word with zero count");

  // one request at a time: no second accept right after one
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> !s_tready_o)
    else $error("request accepted while previous one still in flight");

endmodule
